>>> rtl/core/hsvrgb_pkg.sv
// Shared constants and divide-by-constant helpers for the HSV to RGB converter.
// No dependencies; every other file of the block imports this package.
package hsvrgb_pkg;

  localparam int unsigned HueWidth   = 16;
  localparam int unsigned ChanWidth  = 8;

  localparam logic [8:0]  Deg360     = 9'd360;
  localparam logic [5:0]  Deg60      = 6'd60;
  localparam logic [7:0]  Full       = 8'd255;

  // Reciprocals: floor(x/360) ~ (x*Recip360)>>24 (may be one low),
  // x/60 = (x*Recip60)>>20 exact for x <= 15300,
  // x/255 = (x*Recip255)>>24 exact for x <= 65025.
  localparam logic [15:0] Recip360   = 16'd46603;
  localparam logic [14:0] Recip60    = 15'd17477;
  localparam logic [16:0] Recip255   = 17'd65794;

  localparam logic [2:0] SectorRedYellow    = 3'd0;
  localparam logic [2:0] SectorYellowGreen  = 3'd1;
  localparam logic [2:0] SectorGreenCyan    = 3'd2;
  localparam logic [2:0] SectorCyanBlue     = 3'd3;
  localparam logic [2:0] SectorBlueMagenta  = 3'd4;
  localparam logic [2:0] SectorMagentaRed   = 3'd5;

  // Truncating division by 60 of a product of saturation and a remainder.
  function automatic logic [7:0] div60(input logic [13:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'(Recip60);
    return prod[27:20];
  endfunction

  // Truncating division by 255 of a product of two 8-bit levels.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [32:0] prod;
    prod = 33'(x) * 33'(Recip255);
    return prod[31:24];
  endfunction

endpackage

>>> rtl/core/hsvrgb_if.sv
// Valid/ready channel interfaces for HSV items in and RGB items out.
// Depends on hsvrgb_pkg for the field widths.
interface hsvrgb_in_if
  import hsvrgb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [HueWidth-1:0]  hue;
  logic [ChanWidth-1:0] saturation;
  logic [ChanWidth-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_out_if
  import hsvrgb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ChanWidth-1:0] red;
  logic [ChanWidth-1:0] green;
  logic [ChanWidth-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/hsvrgb_sector.sv
// Splits a hue in 0..359 into a 60-degree sector and the remainder inside it.
// Depends on hsvrgb_pkg for the sector codes.
module hsvrgb_sector
  import hsvrgb_pkg::*;
(
  input  logic [8:0] hue_deg,
  output logic [2:0] sector,
  output logic [5:0] rem
);

  logic [8:0] base;

  always_comb begin
    if (hue_deg >= 9'd300) begin
      sector = SectorMagentaRed;
      base   = 9'd300;
    end else if (hue_deg >= 9'd240) begin
      sector = SectorBlueMagenta;
      base   = 9'd240;
    end else if (hue_deg >= 9'd180) begin
      sector = SectorCyanBlue;
      base   = 9'd180;
    end else if (hue_deg >= 9'd120) begin
      sector = SectorGreenCyan;
      base   = 9'd120;
    end else if (hue_deg >= 9'd60) begin
      sector = SectorYellowGreen;
      base   = 9'd60;
    end else begin
      sector = SectorRedYellow;
      base   = 9'd0;
    end
    rem = 6'(hue_deg - base);
  end

endmodule

>>> rtl/core/hsv_to_rgb_converter_core.sv
// Top level of the HSV to RGB converter: a seven-stage pipeline.
// Depends on hsvrgb_pkg, the channel interfaces and hsvrgb_sector.

// The converter takes one color item per cycle unless the output stalls, as
// hue (any 16-bit value, taken modulo 360), saturation and brightness, and
// returns one item of 8-bit red, green and blue for each. Results leave in
// input order. The work runs through seven register stages: a reciprocal
// multiply for the hue reduction, the correction of that remainder, the sector
// split, the saturation products, the divisions by 60 and 255, the level
// products and the final division with the channel selection. Every stage
// carries its own valid bit and holds when the stage after it is full and
// stalled, so a back-pressured output fills the pipeline before the input
// ready drops, and empty stages still move forward under a stall. With the
// output always ready the sustained rate is one item per clock. A zero
// saturation yields gray: all three channels equal the brightness.
module hsv_to_rgb_converter_core
  import hsvrgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  hsvrgb_in_if.sink    hsv_in,
  hsvrgb_out_if.source rgb_out
);

  localparam int unsigned NumStages = 7;

  logic [NumStages:1] vld;
  logic [NumStages:1] vld_src;
  logic [NumStages:1] load;

  // A stage takes new contents when it is empty or its own contents move on.
  always_comb begin
    load[NumStages] = !vld[NumStages] || rgb_out.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign vld_src = {vld[NumStages-1:1], hsv_in.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (load[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  assign hsv_in.ready  = load[1];
  assign rgb_out.valid = vld[NumStages];

  // Stage 1: estimate the quotient hue/360 with a reciprocal multiply.
  logic [31:0] hue_prod1;
  logic [15:0] hue1;
  logic [7:0]  sat1, val1;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      hue_prod1 <= 32'(hsv_in.hue) * 32'(Recip360);
      hue1      <= hsv_in.hue;
      sat1      <= hsv_in.saturation;
      val1      <= hsv_in.brightness;
    end
  end

  // Stage 2: the estimate is exact or one low, so one conditional subtract
  // brings the remainder into 0..359.
  logic [7:0]  quot1;
  logic [16:0] diff1;
  logic [8:0]  hue_deg_next;
  logic [8:0]  hue_deg2;
  logic [7:0]  sat2, val2;

  always_comb begin
    quot1 = hue_prod1[31:24];
    diff1 = {1'b0, hue1} - 17'(17'(quot1) * 17'(Deg360));
    if (diff1 >= 17'(Deg360)) begin
      hue_deg_next = 9'(diff1 - 17'(Deg360));
    end else begin
      hue_deg_next = diff1[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      hue_deg2 <= hue_deg_next;
      sat2     <= sat1;
      val2     <= val1;
    end
  end

  // Stage 3: sector and remainder.
  logic [2:0] sector_next;
  logic [5:0] rem_next;
  logic [2:0] sector3;
  logic [5:0] rem3;
  logic [7:0] sat3, val3;

  hsvrgb_sector u_sector (
    .hue_deg (hue_deg2),
    .sector  (sector_next),
    .rem     (rem_next)
  );

  always_ff @(posedge clk) begin
    if (load[3]) begin
      sector3 <= sector_next;
      rem3    <= rem_next;
      sat3    <= sat2;
      val3    <= val2;
    end
  end

  // Stage 4: saturation times the remainder and its complement, and the
  // product behind the p level.
  logic [13:0] sat_rem4, sat_cmp4;
  logic [15:0] p_prod4;
  logic [2:0]  sector4;
  logic        gray4;
  logic [7:0]  val4;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      sat_rem4 <= 14'(sat3) * 14'(rem3);
      sat_cmp4 <= 14'(sat3) * 14'(Deg60 - rem3);
      p_prod4  <= 16'(val3) * 16'(Full - sat3);
      sector4  <= sector3;
      gray4    <= (sat3 == '0);
      val4     <= val3;
    end
  end

  // Stage 5: the drops for q and t, and the finished p level.
  logic [7:0] drop_q5, drop_t5, p5;
  logic [2:0] sector5;
  logic       gray5;
  logic [7:0] val5;

  always_ff @(posedge clk) begin
    if (load[5]) begin
      drop_q5 <= div60(sat_rem4);
      drop_t5 <= div60(sat_cmp4);
      p5      <= div255(p_prod4);
      sector5 <= sector4;
      gray5   <= gray4;
      val5    <= val4;
    end
  end

  // Stage 6: products behind the q and t levels.
  logic [15:0] q_prod6, t_prod6;
  logic [7:0]  p6;
  logic [2:0]  sector6;
  logic        gray6;
  logic [7:0]  val6;

  always_ff @(posedge clk) begin
    if (load[6]) begin
      q_prod6 <= 16'(val5) * 16'(Full - drop_q5);
      t_prod6 <= 16'(val5) * 16'(Full - drop_t5);
      p6      <= p5;
      sector6 <= sector5;
      gray6   <= gray5;
      val6    <= val5;
    end
  end

  // Stage 7: finish q and t, then route v, p, q and t by sector.
  logic [7:0] q_lvl, t_lvl;
  logic [7:0] red_next, green_next, blue_next;
  logic [7:0] red, green, blue;

  always_comb begin
    q_lvl = div255(q_prod6);
    t_lvl = div255(t_prod6);
    if (gray6) begin
      red_next   = val6;
      green_next = val6;
      blue_next  = val6;
    end else begin
      case (sector6)
        SectorRedYellow: begin
          red_next = val6;  green_next = t_lvl; blue_next = p6;
        end
        SectorYellowGreen: begin
          red_next = q_lvl; green_next = val6;  blue_next = p6;
        end
        SectorGreenCyan: begin
          red_next = p6;    green_next = val6;  blue_next = t_lvl;
        end
        SectorCyanBlue: begin
          red_next = p6;    green_next = q_lvl; blue_next = val6;
        end
        SectorBlueMagenta: begin
          red_next = t_lvl; green_next = p6;    blue_next = val6;
        end
        default: begin
          red_next = val6;  green_next = p6;    blue_next = q_lvl;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load[7]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign rgb_out.red   = red;
  assign rgb_out.green = green;
  assign rgb_out.blue  = blue;

endmodule

>>> tb/rgb_result_checker.sv
// Checker for the HSV to RGB converter: watches both channels, predicts each color.
// Depends on hsvrgb_pkg for widths, constants and sector codes.
module rgb_result_checker
  import hsvrgb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [HueWidth-1:0]  hue,
  input  logic [ChanWidth-1:0] saturation,
  input  logic [ChanWidth-1:0] brightness,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ChanWidth-1:0] red,
  input  logic [ChanWidth-1:0] green,
  input  logic [ChanWidth-1:0] blue,
  output int unsigned          errors,
  output int unsigned          pending,
  output int unsigned          checked
);

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } rgb_t;

  rgb_t colors_due[$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  task automatic note_error(input string msg);
    if (errors < 40) begin
      $display("%0t: ERROR %s", $realtime, msg);
    end
    errors++;
  endtask

  // Brightness dimmed by a drop of 0..255, truncated.
  function automatic int unsigned dimmed_level(input int unsigned v, input int unsigned drop);
    return (v * (Full - drop)) / Full;
  endfunction

  function automatic rgb_t predict_rgb(input logic [HueWidth-1:0]  h_in,
                                       input logic [ChanWidth-1:0] s_in,
                                       input logic [ChanWidth-1:0] v_in);
    int unsigned h, s, v, rem, p, q, t;
    logic [2:0]  sector;
    rgb_t        c;
    h = h_in % Deg360;
    s = s_in;
    v = v_in;
    if (s == 0) begin
      c = '{red: v_in, green: v_in, blue: v_in};
    end else begin
      sector = 3'(h / Deg60);
      rem    = h % Deg60;
      p      = dimmed_level(v, s);
      q      = dimmed_level(v, (s * rem) / Deg60);
      t      = dimmed_level(v, (s * (Deg60 - rem)) / Deg60);
      case (sector)
        SectorRedYellow:   c = '{red: 8'(v), green: 8'(t), blue: 8'(p)};
        SectorYellowGreen: c = '{red: 8'(q), green: 8'(v), blue: 8'(p)};
        SectorGreenCyan:   c = '{red: 8'(p), green: 8'(v), blue: 8'(t)};
        SectorCyanBlue:    c = '{red: 8'(p), green: 8'(q), blue: 8'(v)};
        SectorBlueMagenta: c = '{red: 8'(t), green: 8'(p), blue: 8'(v)};
        default:           c = '{red: 8'(v), green: 8'(p), blue: 8'(q)};
      endcase
    end
    return c;
  endfunction

  always @(posedge clk) begin
    rgb_t due;
    if (!rst) begin
      if (in_valid && in_ready) begin
        colors_due.push_back(predict_rgb(hue, saturation, brightness));
      end
      if (out_valid && out_ready) begin
        if (colors_due.size() == 0) begin
          note_error($sformatf("unexpected color %0d/%0d/%0d", red, green, blue));
        end else begin
          due = colors_due.pop_front();
          if (red !== due.red) begin
            note_error($sformatf("red: expected %0d, got %0d", due.red, red));
          end
          if (green !== due.green) begin
            note_error($sformatf("green: expected %0d, got %0d", due.green, green));
          end
          if (blue !== due.blue) begin
            note_error($sformatf("blue: expected %0d, got %0d", due.blue, blue));
          end
          checked <= checked + 1;
        end
      end
    end
    pending <= colors_due.size();
  end

endmodule

>>> tb/hsv_to_rgb_converter_core_tb.sv
// Testbench top for the HSV to RGB converter: drives colors, applies back-pressure.
// Depends on hsvrgb_pkg, the channel interfaces, the core and rgb_result_checker.
module hsv_to_rgb_converter_core_tb;
  import hsvrgb_pkg::*;

  // Clock and reset. The clock starts low so the first rising edge comes after
  // every input has been given a known value at time zero.
  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hsvrgb_in_if  hsv_in();
  hsvrgb_out_if rgb_out();

  hsv_to_rgb_converter_core dut (
    .clk     (clk),
    .rst     (rst),
    .hsv_in  (hsv_in),
    .rgb_out (rgb_out)
  );

  int unsigned error_count;
  int unsigned colors_pending;
  int unsigned colors_checked;

  // The checker sees every handshake on both channels, predicts the color of
  // each accepted item and compares it with the item that comes out.
  rgb_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hsv_in.valid),
    .in_ready   (hsv_in.ready),
    .hue        (hsv_in.hue),
    .saturation (hsv_in.saturation),
    .brightness (hsv_in.brightness),
    .out_valid  (rgb_out.valid),
    .out_ready  (rgb_out.ready),
    .red        (rgb_out.red),
    .green      (rgb_out.green),
    .blue       (rgb_out.blue),
    .errors     (error_count),
    .pending    (colors_pending),
    .checked    (colors_checked)
  );

  // Percent of cycles in which the sender holds back an item and in which the
  // receiver refuses one. The main sequence changes them between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned colors_sent   = 0;

  // Receiver: ready is drawn afresh at each rising edge, so stalls land on
  // every stage of the pipeline as it fills and drains.
  always @(posedge clk) begin
    rgb_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hands one color to the block. Idle cycles come first, with valid low and
  // random payload on the wires; then the item is held until it is accepted.
  // Valid is only lowered on an idle cycle, never in the step that raises it.
  task automatic send_color(input logic [HueWidth-1:0]  h,
                            input logic [ChanWidth-1:0] s,
                            input logic [ChanWidth-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hsv_in.valid      <= 1'b0;
      hsv_in.hue        <= HueWidth'($urandom);
      hsv_in.saturation <= ChanWidth'($urandom);
      hsv_in.brightness <= ChanWidth'($urandom);
      @(posedge clk);
    end
    hsv_in.valid      <= 1'b1;
    hsv_in.hue        <= h;
    hsv_in.saturation <= s;
    hsv_in.brightness <= v;
    // Ready is read right after the edge, before any register of the block
    // has taken its new value, so this sees the handshake of that edge.
    do @(posedge clk); while (!hsv_in.ready);
    colors_sent++;
  endtask

  // A channel level that favors the two ends of the range.
  function automatic logic [ChanWidth-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ChanWidth'($urandom_range(1, 3));
      default: return ChanWidth'($urandom);
    endcase
  endfunction

  // A hue that is mostly within two turns, sometimes right at a sector
  // boundary and sometimes anywhere in the 16-bit range.
  function automatic logic [HueWidth-1:0] pick_hue();
    int unsigned edge_deg;
    case ($urandom_range(0, 9))
      0: return HueWidth'($urandom);
      1: begin
        edge_deg = Deg60 * $urandom_range(1, 12);
        return HueWidth'(edge_deg - $urandom_range(0, 1));
      end
      default: return HueWidth'($urandom_range(0, 719));
    endcase
  endfunction

  // Idle shares of the three random phases: a slow receiver, a slow sender,
  // then full rate in both directions.
  int unsigned phase_send_idle [3] = '{8, 76, 0};
  int unsigned phase_recv_idle [3] = '{76, 8, 0};

  initial begin
    int unsigned phase;
    int unsigned n;
    rst               <= 1'b1;
    hsv_in.valid      <= 1'b0;
    hsv_in.hue        <= '0;
    hsv_in.saturation <= '0;
    hsv_in.brightness <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = phase_send_idle[0];
    recv_idle_pct = phase_recv_idle[0];

    // Directed colors: both sides of every sector boundary, the last degree
    // of a turn and wrapped hues, gray at several hues, black, full white and
    // the smallest nonzero saturation.
    send_color(16'd0,     8'd255, 8'd255);
    send_color(16'd59,    8'd255, 8'd255);
    send_color(16'd60,    8'd255, 8'd255);
    send_color(16'd119,   8'd255, 8'd255);
    send_color(16'd120,   8'd255, 8'd255);
    send_color(16'd179,   8'd255, 8'd255);
    send_color(16'd180,   8'd255, 8'd255);
    send_color(16'd239,   8'd255, 8'd255);
    send_color(16'd240,   8'd255, 8'd255);
    send_color(16'd299,   8'd255, 8'd255);
    send_color(16'd300,   8'd255, 8'd255);
    send_color(16'd359,   8'd255, 8'd255);
    send_color(16'd360,   8'd255, 8'd255);
    send_color(16'd65535, 8'd255, 8'd255);
    send_color(16'd30,    8'd0,   8'd200);
    send_color(16'd65535, 8'd0,   8'd255);
    send_color(16'd200,   8'd0,   8'd0);
    send_color(16'd90,    8'd255, 8'd0);
    send_color(16'd45,    8'd1,   8'd255);
    send_color(16'd150,   8'd128, 8'd1);
    send_color(16'd65520, 8'd170, 8'd85);
    send_color(16'd719,   8'd255, 8'd128);
    send_color(16'd720,   8'd85,  8'd170);

    // Random colors in three phases of different back-pressure. The block
    // keeps no state between items, so phases need not wait for the pipeline
    // to drain.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase_send_idle[phase];
      recv_idle_pct = phase_recv_idle[phase];
      for (n = 0; n < 134; n++) begin
        send_color(pick_hue(), pick_level(), pick_level());
      end
    end
    hsv_in.valid <= 1'b0;

    // Drain: the count of colors still due is updated at each edge, so when the
    // loop below first reads it, it already includes the last accepted item.
    do @(posedge clk); while (colors_pending != 0);
    // Wait on past the drain, so that a stray extra item would show.
    repeat (30) @(posedge clk);

    $display("%0d colors sent, %0d checked; gray, black, wrapped hues and every sector",
             colors_sent, colors_checked);
    $display("ran under a slow receiver, a slow sender and full rate");
    if (error_count == 0) begin
      $display("hsv_to_rgb_converter_core_tb: done, clean");
    end else begin
      $display("hsv_to_rgb_converter_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("timeout with %0d colors still due", colors_pending);
    $display("hsv_to_rgb_converter_core_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_if.sv
rtl/core/hsvrgb_sector.sv
rtl/core/hsv_to_rgb_converter_core.sv
tb/rgb_result_checker.sv
tb/hsv_to_rgb_converter_core_tb.sv
